@@ rtl/ust_pkg.sv @@
// ----------------------------------------------------------------------------
// ust_pkg: shared definitions for the unique set table
// Operation and status codes, field widths and the command that the
// control logic broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package ust_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 5;

	typedef enum logic [KIND_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Command seen by all cells in the cycle an item executes.
	typedef struct packed {
		logic               lookup;  // compare against the stored entries
		logic               shift;   // delete: compact entries above the hit
		logic               write;   // insert: store value at the fill position
		logic [VALUE_W-1:0] value;
	} cmd_t;

endpackage

@@ rtl/ust_cell.sv @@
// ----------------------------------------------------------------------------
// ust_cell: one slot of the unique set table
// Holds one entry, compares it with the broadcast value, passes the hit
// chain to the next slot and takes its upper neighbor's entry on a delete.
// ----------------------------------------------------------------------------
module ust_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                       clk,
	input  ust_pkg::cmd_t              cmd,
	input  logic [CNT_W-1:0]           count,
	input  logic                       hit_in,
	input  logic [ust_pkg::VALUE_W-1:0] upper_entry,
	output logic                       hit_out,
	output logic [ust_pkg::VALUE_W-1:0] entry
);

	localparam logic [CNT_W:0] NEXT_IDX = (CNT_W+1)'(IDX + 1);

	logic [ust_pkg::VALUE_W-1:0] entry_q;
	logic                        occupied;
	logic                        match;
	logic                        upper_occupied;

	assign occupied       = CNT_W'(IDX) < count;
	assign upper_occupied = NEXT_IDX < {1'b0, count};
	assign match          = cmd.lookup && occupied && (entry_q == cmd.value);
	assign hit_out        = hit_in | match;
	assign entry          = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.write && (count == CNT_W'(IDX))) begin
			entry_q <= cmd.value;
		end else if (cmd.shift && hit_out && upper_occupied) begin
			entry_q <= upper_entry;
		end
	end

endmodule

@@ rtl/unique_set_table.sv @@
// ----------------------------------------------------------------------------
// unique_set_table: packed table of unique values with an occupancy count
// Insert, delete with compaction, and clear, on a chain of storage cells.
// ----------------------------------------------------------------------------
// Usage: an input item (kind, value) enters on in_valid/in_ready and each
// item gives exactly one result item (status, occupancy) on
// out_valid/out_ready, in order. An accepted item is held in an input
// register and executes when no result is held back: every cell compares its
// entry with the value at once, and a delete moves each entry above the hit
// down by one slot in that same cycle. The result is registered, so out_valid
// rises in the cycle after the item executes. One item per cycle is sustained
// as long as the receiver keeps out_ready high. The cycle time is set by the
// compare and the hit chain that runs through all CAPACITY cells.
// When the receiver stalls, the held result blocks execution of the next
// item, which waits in the input register; in_ready then drops.
// Reset clears the occupancy count and the handshake state only; the stored
// entries are not cleared, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module unique_set_table #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ust_pkg::KIND_W-1:0]          kind,
	input  logic signed [ust_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ust_pkg::STATUS_W-1:0]        status,
	output logic [ust_pkg::OCC_W-1:0]           occupancy
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic                         pend_q;
	logic [ust_pkg::KIND_W-1:0]   kind_q;
	logic [ust_pkg::VALUE_W-1:0]  value_q;
	logic [CNT_W-1:0]             count_q;
	logic                         out_valid_q;
	ust_pkg::status_t             status_q;
	logic [ust_pkg::OCC_W-1:0]    occ_q;

	logic                         exec;
	logic                         found;
	ust_pkg::op_t                 op;
	ust_pkg::cmd_t                cmd;
	ust_pkg::status_t             status_next;
	logic [CNT_W-1:0]             count_next;

	logic [CAPACITY:0]                       hit;
	logic [ust_pkg::VALUE_W-1:0]             entry [CAPACITY];

	assign exec     = pend_q && (!out_valid_q || out_ready);
	assign in_ready = !pend_q || exec;
	assign op       = ust_pkg::op_t'(kind_q);
	assign hit[0]   = 1'b0;
	assign found    = hit[CAPACITY];

	always_comb begin
		cmd.lookup  = exec && ((op == ust_pkg::OP_INSERT) || (op == ust_pkg::OP_DELETE));
		cmd.value   = value_q;
		cmd.shift   = exec && (op == ust_pkg::OP_DELETE);
		cmd.write   = exec && (op == ust_pkg::OP_INSERT) && !found && (count_q != CAP_CNT);
		status_next = ust_pkg::ST_DONE;
		count_next  = count_q;
		unique case (op)
			ust_pkg::OP_INSERT: begin
				if (found) begin
					status_next = ust_pkg::ST_PRESENT;
				end else if (count_q == CAP_CNT) begin
					status_next = ust_pkg::ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			ust_pkg::OP_DELETE: begin
				if (found) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status_next = ust_pkg::ST_ABSENT;
				end
			end
			ust_pkg::OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				status_next = ust_pkg::ST_DONE;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ust_pkg::VALUE_W-1:0] upper;
		if (i == CAPACITY - 1) begin : g_top
			assign upper = entry[i];
		end else begin : g_mid
			assign upper = entry[i+1];
		end
		ust_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.count       (count_q),
			.hit_in      (hit[i]),
			.upper_entry (upper),
			.hit_out     (hit[i+1]),
			.entry       (entry[i])
		);
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			value_q <= value;
		end
		if (exec) begin
			status_q <= status_next;
			occ_q    <= ust_pkg::OCC_W'(count_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_ready) begin
				pend_q <= in_valid;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule

@@ tb/sv/tb_unique_set_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_set_table: self-checking bench for the unique set table
// Drives insert, delete, clear and no-op items with random handshake gaps
// and result back-pressure. A tracker keeps its own copy of the table and
// the count and compares every result with the one it expects.
// ----------------------------------------------------------------------------
module tb_unique_set_table;

	localparam int CAPACITY      = 16;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int CALM_TAIL     = 200;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_POOL      = 24;

	class set_table_tracker;
		typedef struct {
			ust_pkg::status_t            st;
			logic [ust_pkg::OCC_W-1:0]   occ;
		} reply_t;

		logic [ust_pkg::VALUE_W-1:0] words [CAPACITY];
		int unsigned        fill;
		reply_t             pending_replies[$];
		int unsigned        mismatches;
		int unsigned        replies_checked;
		int unsigned        peak_fill;
		int unsigned        clears;
		int unsigned        status_hits[4];

		function new();
			fill = 0;
			mismatches = 0;
			replies_checked = 0;
			peak_fill = 0;
			clears = 0;
			foreach (status_hits[i])
				status_hits[i] = 0;
		endfunction

		// Applies one operation to the tracked table and gives its status.
		function ust_pkg::status_t apply_op(ust_pkg::op_t op,
			logic [ust_pkg::VALUE_W-1:0] v);
			int hit;
			hit = -1;
			for (int i = 0; i < fill; i++) begin
				if (hit < 0 && words[i] == v)
					hit = i;
			end
			case (op)
				ust_pkg::OP_INSERT: begin
					if (hit >= 0)
						return ust_pkg::ST_PRESENT;
					if (fill >= CAPACITY)
						return ust_pkg::ST_FULL;
					words[fill] = v;
					fill++;
					return ust_pkg::ST_DONE;
				end
				ust_pkg::OP_DELETE: begin
					if (hit < 0)
						return ust_pkg::ST_ABSENT;
					for (int i = hit; i + 1 < fill; i++)
						words[i] = words[i + 1];
					fill--;
					return ust_pkg::ST_DONE;
				end
				ust_pkg::OP_CLEAR: begin
					fill = 0;
					clears++;
					return ust_pkg::ST_DONE;
				end
				default: return ust_pkg::ST_DONE;
			endcase
		endfunction

		function void note_request(ust_pkg::op_t op, logic [ust_pkg::VALUE_W-1:0] v);
			reply_t r;
			r.st = apply_op(op, v);
			r.occ = fill[ust_pkg::OCC_W-1:0];
			pending_replies.push_back(r);
			if (fill > peak_fill)
				peak_fill = fill;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR at %0t: %s", $realtime, what);
		endfunction

		function void check_reply(logic [ust_pkg::STATUS_W-1:0] st,
			logic [ust_pkg::OCC_W-1:0] occ);
			reply_t r;
			replies_checked++;
			if (pending_replies.size() == 0) begin
				flag($sformatf("result (status %0d, occupancy %0d) with no item outstanding",
					st, occ));
				return;
			end
			r = pending_replies.pop_front();
			status_hits[r.st]++;
			if (st !== r.st)
				flag($sformatf("status expected %s, got %0d", r.st.name(), st));
			if (occ !== r.occ)
				flag($sformatf("occupancy expected %0d, got %0d", r.occ, occ));
		endfunction
	endclass

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic [ust_pkg::KIND_W-1:0]          kind      = '0;
	logic signed [ust_pkg::VALUE_W-1:0]  value     = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [ust_pkg::STATUS_W-1:0]        status;
	logic [ust_pkg::OCC_W-1:0]           occupancy;

	set_table_tracker            tracker;
	bit                          idle_on = 1'b1;
	int unsigned                 cycles = 0;
	int unsigned                 items_sent = 0;
	int                          stall_left = 0;
	logic [ust_pkg::VALUE_W-1:0] pool [MAX_POOL];
	int                          pool_size;

	unique_set_table #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.occupancy(occupancy)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				tracker.pending_replies.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: checks each accepted result and stalls in random bursts.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_reply(status, occupancy);
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 8);
			out_ready <= (stall_left == 0);
		end
	end

	task automatic send_item(input ust_pkg::op_t op, input logic [ust_pkg::VALUE_W-1:0] v);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_request(op, v);
		items_sent++;
	endtask

	initial begin
		int r;
		ust_pkg::op_t op;
		logic [ust_pkg::VALUE_W-1:0] v;

		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, extremes, duplicates, a middle delete,
		// the unused kind, then a fill to capacity and the full-table cases.
		send_item(ust_pkg::OP_CLEAR, 32'h0000_0000);
		send_item(ust_pkg::OP_DELETE, 32'h0000_0005);
		send_item(ust_pkg::OP_INSERT, 32'h8000_0000);
		send_item(ust_pkg::OP_INSERT, 32'h7FFF_FFFF);
		send_item(ust_pkg::OP_INSERT, 32'h0000_0000);
		send_item(ust_pkg::OP_INSERT, 32'hFFFF_FFFF);
		send_item(ust_pkg::OP_INSERT, 32'h7FFF_FFFF);
		send_item(ust_pkg::OP_DELETE, 32'h0000_0000);
		send_item(ust_pkg::OP_NONE, 32'hFFFF_FFFF);
		for (int i = 0; i < CAPACITY - 3; i++)
			send_item(ust_pkg::OP_INSERT, 32'h5555_0000 | i);
		send_item(ust_pkg::OP_INSERT, 32'h1234_5678);
		send_item(ust_pkg::OP_INSERT, 32'h8000_0000);
		send_item(ust_pkg::OP_DELETE, 32'h7FFF_FFFF);
		send_item(ust_pkg::OP_CLEAR, 32'hA5A5_A5A5);

		// Random part: values come mostly from a small, changing pool so that
		// duplicates, hits and a full table happen often.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 100) % 3 != 2);
			if (n % 150 == 0) begin
				pool_size = $urandom_range(8, MAX_POOL);
				for (int i = 0; i < MAX_POOL; i++) begin
					case ($urandom_range(0, 11))
						0: pool[i] = 32'h8000_0000;
						1: pool[i] = 32'h7FFF_FFFF;
						2: pool[i] = 32'hFFFF_FFFF;
						3: pool[i] = 32'h0000_0000;
						default: pool[i] = $urandom;
					endcase
				end
			end
			r = $urandom_range(0, 99);
			if (r < 55)
				op = ust_pkg::OP_INSERT;
			else if (r < 93)
				op = ust_pkg::OP_DELETE;
			else if (r < 97)
				op = ust_pkg::OP_CLEAR;
			else
				op = ust_pkg::OP_NONE;
			if ($urandom_range(0, 9) == 0)
				v = $urandom;
			else
				v = pool[$urandom_range(0, pool_size - 1)];
			send_item(op, v);
		end
		in_valid <= 1'b0;

		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Ran %0d items, %0d results: %0d done, %0d already present, %0d not found,",
			items_sent, tracker.replies_checked,
			tracker.status_hits[ust_pkg::ST_DONE],
			tracker.status_hits[ust_pkg::ST_PRESENT],
			tracker.status_hits[ust_pkg::ST_ABSENT]);
		$display("%0d table full; peak occupancy %0d, %0d clears, %0d mismatches.",
			tracker.status_hits[ust_pkg::ST_FULL], tracker.peak_fill, tracker.clears,
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
